### design/csm_pkg.sv
// shared types, field widths and function codes for the signature table block
package csm_pkg;

    localparam int ENTRIES_DEF    = 64;
    localparam int COMPONENTS_DEF = 32;

    localparam int ID_W   = 6;
    localparam int MASK_W = 32;
    localparam int FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   result_id;
        logic              created;
        logic              full_res;
        logic              valid_res;
        logic [MASK_W-1:0] sig_out;
        logic              last;
    } t_res;

endpackage

### design/csm_sig_ram.sv
// signature table memory, one write port and one registered read port
module csm_sig_ram #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6,
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/csm_engine.sv
// sequencer: table scan for find-or-create and query, read-back, append
module csm_engine #(
    parameter int ENTRIES = 64,
    parameter int SIG_W   = 32,
    parameter int IDX_W   = 6,
    parameter int CNT_W   = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [csm_pkg::FUNC_W-1:0]    i_func,
    input  logic [csm_pkg::MASK_W-1:0]    i_sig_mask,
    input  logic [csm_pkg::MASK_W-1:0]    i_with_mask,
    input  logic [csm_pkg::MASK_W-1:0]    i_without_mask,
    input  logic [csm_pkg::ID_W-1:0]      i_entry_id,
    input  logic                          i_out_space,
    output logic                          o_push,
    output csm_pkg::t_res                 o_res,
    output logic                          o_wr_en,
    output logic [IDX_W-1:0]              o_wr_addr,
    output logic [SIG_W-1:0]              o_wr_data,
    output logic                          o_rd_en,
    output logic [IDX_W-1:0]              o_rd_addr,
    input  logic [SIG_W-1:0]              i_rd_data
);

    import csm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_QEND = 3'd4;
    localparam logic [2:0] ST_ONE  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [FUNC_W-1:0] r_func, n_func;
    logic [SIG_W-1:0]  r_sig, n_sig;
    logic [SIG_W-1:0]  r_need, n_need;
    logic [SIG_W-1:0]  r_without, n_without;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_iss, n_iss;
    logic [IDX_W-1:0]  r_didx, n_didx;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pidx, n_pidx;
    logic [SIG_W-1:0]  r_psig, n_psig;
    t_res              r_one, n_one;

    logic [SIG_W-1:0]  in_sig;
    logic              hit;
    logic              qmatch;
    logic              scan_done;
    logic              table_full;

    assign in_sig     = i_sig_mask[SIG_W-1:0];
    assign hit        = (i_rd_data == r_sig);
    assign qmatch     = ((i_rd_data & r_need) == r_need) && ((i_rd_data & r_without) == '0);
    assign scan_done  = (r_iss == r_cnt);
    assign table_full = (r_cnt == CNT_W'(ENTRIES));

    assign o_ready   = (r_state == ST_IDLE);
    assign o_wr_addr = r_cnt[IDX_W-1:0];
    assign o_wr_data = r_sig;

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_sig     = r_sig;
        n_need    = r_need;
        n_without = r_without;
        n_cnt     = r_cnt;
        n_iss     = r_iss;
        n_didx    = r_didx;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_psig    = r_psig;
        n_one     = r_one;
        o_rd_en   = 1'b0;
        o_rd_addr = r_iss[IDX_W-1:0];
        o_wr_en   = 1'b0;
        o_push    = 1'b0;
        o_res     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_func    = i_func;
                    n_sig     = in_sig;
                    n_need    = in_sig | i_with_mask[SIG_W-1:0];
                    n_without = i_without_mask[SIG_W-1:0];
                    n_pend    = 1'b0;
                    n_one     = '0;
                    n_one.last = 1'b1;
                    case (i_func)
                        FUNC_FIND: begin
                            if (r_cnt == '0) begin
                                n_state = ST_FIN;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_iss     = CNT_W'(1);
                                n_didx    = '0;
                                n_state   = ST_SCAN;
                            end
                        end
                        FUNC_READ: begin
                            n_one.result_id = i_entry_id;
                            if ({1'b0, i_entry_id} < 7'(r_cnt)) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = i_entry_id[IDX_W-1:0];
                                n_state   = ST_RD;
                            end else begin
                                n_state = ST_ONE;
                            end
                        end
                        FUNC_QUERY: begin
                            // empty query signature matches nothing
                            if ((in_sig != '0) && (r_cnt != '0)) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_iss     = CNT_W'(1);
                                n_didx    = '0;
                                n_state   = ST_SCAN;
                            end else begin
                                n_state = ST_ONE;
                            end
                        end
                        default: begin
                            n_state = ST_ONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (r_func == FUNC_FIND) begin
                    if (hit) begin
                        o_res.result_id = ID_W'(r_didx);
                        o_res.valid_res = 1'b1;
                        o_res.sig_out   = MASK_W'(i_rd_data);
                        o_res.last      = 1'b1;
                        if (i_out_space) begin
                            o_push  = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end else if (scan_done) begin
                        n_state = ST_FIN;
                    end else begin
                        o_rd_en = 1'b1;
                        n_iss   = r_iss + CNT_W'(1);
                        n_didx  = r_iss[IDX_W-1:0];
                    end
                end else begin
                    // a match is held back until the next one shows it was not final
                    o_res.result_id = ID_W'(r_pidx);
                    o_res.valid_res = 1'b1;
                    o_res.sig_out   = MASK_W'(r_psig);
                    if (!(qmatch && r_pend && !i_out_space)) begin
                        if (qmatch) begin
                            o_push = r_pend;
                            n_pend = 1'b1;
                            n_pidx = r_didx;
                            n_psig = i_rd_data;
                        end
                        if (scan_done) begin
                            n_state = ST_QEND;
                        end else begin
                            o_rd_en = 1'b1;
                            n_iss   = r_iss + CNT_W'(1);
                            n_didx  = r_iss[IDX_W-1:0];
                        end
                    end
                end
            end

            ST_RD: begin
                o_res           = r_one;
                o_res.valid_res = 1'b1;
                o_res.sig_out   = MASK_W'(i_rd_data);
                if (i_out_space) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            ST_FIN: begin
                o_res.last = 1'b1;
                if (table_full) begin
                    o_res.full_res = 1'b1;
                end else begin
                    o_res.result_id = ID_W'(r_cnt);
                    o_res.created   = 1'b1;
                    o_res.valid_res = 1'b1;
                    o_res.sig_out   = MASK_W'(r_sig);
                end
                if (i_out_space) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                    if (!table_full) begin
                        o_wr_en = 1'b1;
                        n_cnt   = r_cnt + CNT_W'(1);
                    end
                end
            end

            ST_QEND: begin
                o_res.last = 1'b1;
                if (r_pend) begin
                    o_res.result_id = ID_W'(r_pidx);
                    o_res.valid_res = 1'b1;
                    o_res.sig_out   = MASK_W'(r_psig);
                end
                if (i_out_space) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            ST_ONE: begin
                o_res = r_one;
                if (i_out_space) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_sig     <= n_sig;
        r_need    <= n_need;
        r_without <= n_without;
        r_iss     <= n_iss;
        r_didx    <= n_didx;
        r_pidx    <= n_pidx;
        r_psig    <= n_psig;
        r_one     <= n_one;
    end

endmodule

### design/component_signature_table_match.sv
// top level of the component signature table: engine, table memory, output register
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------------
//  request | in        | i_valid / o_ready   | func, sig_mask, with_mask, without_mask, id
//  result  | out       | o_valid / i_ready   | result_id, created, full_res, valid_res,
//          |           |                     | sig_out, last
//
// find-or-create and query scan the stored signatures one per cycle, while the result
// register has space, through the single read port of the table memory, count <= ENTRIES
// read-back reads the entry, then gives its beat; an unused func code gives an empty beat
// reset (synchronous, active low) clears the entry count; table contents are not
// cleared, only entries below the count are ever read, so no clearing pass is needed
// a stalled result beat freezes the scan in place, the memory read data holds meanwhile
// the next request is taken as soon as the last beat of the previous one is registered
module component_signature_table_match #(
    parameter int ENTRIES    = csm_pkg::ENTRIES_DEF,
    parameter int COMPONENTS = csm_pkg::COMPONENTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [csm_pkg::FUNC_W-1:0]    i_func,
    input  logic [csm_pkg::MASK_W-1:0]    i_sig_mask,
    input  logic [csm_pkg::MASK_W-1:0]    i_with_mask,
    input  logic [csm_pkg::MASK_W-1:0]    i_without_mask,
    input  logic [csm_pkg::ID_W-1:0]      i_entry_id,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [csm_pkg::ID_W-1:0]      o_result_id,
    output logic                          o_created,
    output logic                          o_full_res,
    output logic                          o_valid_res,
    output logic [csm_pkg::MASK_W-1:0]    o_sig_out,
    output logic                          o_last
);

    import csm_pkg::*;

    // stored signature width: mask bits beyond the component count are dropped
    localparam int SIG_W = (COMPONENTS > MASK_W) ? MASK_W : COMPONENTS;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // engine to memory
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [SIG_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [SIG_W-1:0] rd_data;

    // engine to output register
    logic  push;
    t_res  eng_res;
    logic  out_space;

    // output register: one result beat
    logic  r_ov;
    t_res  r_res;

    assign out_space = !r_ov || i_ready;

    csm_engine #(
        .ENTRIES (ENTRIES),
        .SIG_W   (SIG_W),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_sig_mask     (i_sig_mask),
        .i_with_mask    (i_with_mask),
        .i_without_mask (i_without_mask),
        .i_entry_id     (i_entry_id),
        .i_out_space    (out_space),
        .o_push         (push),
        .o_res          (eng_res),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data)
    );

    csm_sig_ram #(
        .DEPTH (ENTRIES),
        .IDX_W (IDX_W),
        .WIDTH (SIG_W)
    ) u_sig_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result beat register, loaded only when empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (push) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_res <= eng_res;
        end
    end

    assign o_valid     = r_ov;
    assign o_result_id = r_res.result_id;
    assign o_created   = r_res.created;
    assign o_full_res  = r_res.full_res;
    assign o_valid_res = r_res.valid_res;
    assign o_sig_out   = r_res.sig_out;
    assign o_last      = r_res.last;

    // a create and a refusal never come together
    a_create_xor_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_created && o_full_res))
        else $error("created and full flagged on one beat");

    // a refused create reports no entry and ends the request
    a_full_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_full_res) |-> (!o_valid_res && o_last))
        else $error("full beat carries an entry or is not final");

    // a beat without an entry is always the only and final beat
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> o_last)
        else $error("empty result beat is not final");

    // a created id lies inside the table
    a_created_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_created) |-> ({1'b0, o_result_id} < 7'(ENTRIES)))
        else $error("created id beyond table depth");

endmodule

### tb/testbench.sv
// self-checking testbench for the component signature table: directed rows, then random traffic
`timescale 1ns / 1ps

module testbench;

    import csm_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;   // unused code, answered with an empty beat

    localparam int TABLE_LIMIT = (ENTRIES_DEF > 64) ? 64 : ENTRIES_DEF;
    localparam logic [MASK_W-1:0] COMP_MASK =
        (COMPONENTS_DEF >= 32) ? '1 : ((32'd1 << COMPONENTS_DEF) - 32'd1);

    localparam int RANDOM_ITEMS  = 250;
    localparam int DRAIN_EVERY   = 90;     // sender pauses until all results are in
    localparam int TAIL_CYCLES   = 100;
    localparam int STALL_LIMIT   = 2000;   // cycles without any beat before giving up

    // one directed request; when typed is set, want is the whole expected answer
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [MASK_W-1:0] sig;
        logic [MASK_W-1:0] also;
        logic [MASK_W-1:0] without;
        logic [ID_W-1:0]   eid;
        logic              typed;
        t_res              want;
    } t_stim_row;

    localparam t_res EMPTY_BEAT = '{6'd0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b1};
    localparam t_res NO_TYPE    = '0;

    localparam int NUM_DIRECTED = 23;
    localparam t_stim_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        // empty table: read below and at the top id, query, spare code
        '{FUNC_READ,  32'h0,        32'h0,        32'h0,        6'd0,  1'b1, EMPTY_BEAT},
        '{FUNC_READ,  32'h0,        32'h0,        32'h0,        6'd63, 1'b1,
          '{6'd63, 1'b0, 1'b0, 1'b0, 32'h0, 1'b1}},
        '{FUNC_QUERY, 32'hFFFFFFFF, 32'h0,        32'h0,        6'd0,  1'b1, EMPTY_BEAT},
        '{FUNC_SPARE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 6'd63, 1'b1, EMPTY_BEAT},
        // creates, the empty signature among them
        '{FUNC_FIND,  32'h0,        32'hFFFFFFFF, 32'hFFFFFFFF, 6'd63, 1'b1,
          '{6'd0, 1'b1, 1'b0, 1'b1, 32'h0, 1'b1}},
        '{FUNC_FIND,  32'hFFFFFFFF, 32'h0,        32'h0,        6'd0,  1'b1,
          '{6'd1, 1'b1, 1'b0, 1'b1, 32'hFFFFFFFF, 1'b1}},
        '{FUNC_FIND,  32'h00000001, 32'h0,        32'h0,        6'd0,  1'b1,
          '{6'd2, 1'b1, 1'b0, 1'b1, 32'h00000001, 1'b1}},
        '{FUNC_FIND,  32'h80000000, 32'h0,        32'h0,        6'd0,  1'b1,
          '{6'd3, 1'b1, 1'b0, 1'b1, 32'h80000000, 1'b1}},
        // finds that hit
        '{FUNC_FIND,  32'hFFFFFFFF, 32'h0,        32'h0,        6'd0,  1'b1,
          '{6'd1, 1'b0, 1'b0, 1'b1, 32'hFFFFFFFF, 1'b1}},
        '{FUNC_FIND,  32'h0,        32'h0,        32'h0,        6'd0,  1'b1,
          '{6'd0, 1'b0, 1'b0, 1'b1, 32'h0, 1'b1}},
        // read back, and read beyond the count
        '{FUNC_READ,  32'h0,        32'h0,        32'h0,        6'd1,  1'b1,
          '{6'd1, 1'b0, 1'b0, 1'b1, 32'hFFFFFFFF, 1'b1}},
        '{FUNC_READ,  32'hFFFFFFFF, 32'h0,        32'h0,        6'd3,  1'b1,
          '{6'd3, 1'b0, 1'b0, 1'b1, 32'h80000000, 1'b1}},
        '{FUNC_READ,  32'h0,        32'h0,        32'h0,        6'd4,  1'b1,
          '{6'd4, 1'b0, 1'b0, 1'b0, 32'h0, 1'b1}},
        // empty query signature matches nothing even with a with mask
        '{FUNC_QUERY, 32'h0,        32'hFFFFFFFF, 32'h0,        6'd0,  1'b1, EMPTY_BEAT},
        // queries left to the predictor, with a create, a read-back and a spare code among them
        '{FUNC_QUERY, 32'h00000001, 32'h0,        32'h0,        6'd0,  1'b0, NO_TYPE},
        '{FUNC_QUERY, 32'h80000000, 32'h00000001, 32'h0,        6'd0,  1'b0, NO_TYPE},
        '{FUNC_QUERY, 32'h00000001, 32'h0,        32'h80000000, 6'd0,  1'b0, NO_TYPE},
        '{FUNC_QUERY, 32'hFFFFFFFF, 32'h0,        32'h0,        6'd0,  1'b0, NO_TYPE},
        '{FUNC_QUERY, 32'h00000001, 32'h0,        32'hFFFFFFFF, 6'd0,  1'b0, NO_TYPE},
        '{FUNC_FIND,  32'hA5A5A5A5, 32'h5A5A5A5A, 32'hA5A5A5A5, 6'd42, 1'b1,
          '{6'd4, 1'b1, 1'b0, 1'b1, 32'hA5A5A5A5, 1'b1}},
        '{FUNC_QUERY, 32'hA5A5A5A5, 32'h0,        32'h5A5A5A5A, 6'd0,  1'b0, NO_TYPE},
        '{FUNC_READ,  32'h0,        32'hFFFFFFFF, 32'hFFFFFFFF, 6'd0,  1'b1,
          '{6'd0, 1'b0, 1'b0, 1'b1, 32'h0, 1'b1}},
        '{FUNC_SPARE, 32'h0,        32'h0,        32'h0,        6'd0,  1'b1, EMPTY_BEAT}
    };

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic [FUNC_W-1:0] i_func         = FUNC_FIND;
    logic [MASK_W-1:0] i_sig_mask     = '0;
    logic [MASK_W-1:0] i_with_mask    = '0;
    logic [MASK_W-1:0] i_without_mask = '0;
    logic [ID_W-1:0]   i_entry_id     = '0;
    logic              i_ready        = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [ID_W-1:0]   o_result_id;
    logic              o_created;
    logic              o_full_res;
    logic              o_valid_res;
    logic [MASK_W-1:0] o_sig_out;
    logic              o_last;

    // shadow copy of the table, updated when a request beat is accepted
    logic [MASK_W-1:0] shadow_sigs [64];
    int                shadow_count = 0;

    t_res op_results [$];          // beats caused by the request just accepted
    t_res table_results_due [$];   // beats still owed by the block, oldest first

    int error_count = 0;
    int beat_count  = 0;
    int burst_left  = 0;

    int       ready_phase = 0;
    int       ready_mode  = 0;

    component_signature_table_match #(
        .ENTRIES    (ENTRIES_DEF),
        .COMPONENTS (COMPONENTS_DEF)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_sig_mask     (i_sig_mask),
        .i_with_mask    (i_with_mask),
        .i_without_mask (i_without_mask),
        .i_entry_id     (i_entry_id),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_id    (o_result_id),
        .o_created      (o_created),
        .o_full_res     (o_full_res),
        .o_valid_res    (o_valid_res),
        .o_sig_out      (o_sig_out),
        .o_last         (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // prints one line per mismatch and counts it
    task automatic report_mismatch(input string msg);
        $display("ERROR: %s (at %0t)", msg, $realtime);
        error_count++;
    endtask

    function automatic void add_beat(input int id, input logic created, input logic full,
                                     input logic valid, input logic [MASK_W-1:0] sig,
                                     input logic last);
        t_res beat;
        beat.result_id = id[ID_W-1:0];
        beat.created   = created;
        beat.full_res  = full;
        beat.valid_res = valid;
        beat.sig_out   = sig;
        beat.last      = last;
        op_results.push_back(beat);
    endfunction

    // works out the beats for one request and updates the shadow table
    function automatic void predict_table_op(input logic [FUNC_W-1:0] func,
                                             input logic [MASK_W-1:0] sig_in,
                                             input logic [MASK_W-1:0] also_in,
                                             input logic [MASK_W-1:0] without_in,
                                             input logic [ID_W-1:0]   eid);
        logic [MASK_W-1:0] sig;
        logic [MASK_W-1:0] need;
        logic [MASK_W-1:0] without_bits;
        logic              found;
        sig          = sig_in & COMP_MASK;
        need         = sig | (also_in & COMP_MASK);
        without_bits = without_in & COMP_MASK;
        found        = 1'b0;
        op_results.delete();
        case (func)
            FUNC_FIND: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (!found && shadow_sigs[i] == sig) begin
                        add_beat(i, 1'b0, 1'b0, 1'b1, sig, 1'b1);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    if (shadow_count >= TABLE_LIMIT) begin
                        add_beat(0, 1'b0, 1'b1, 1'b0, '0, 1'b1);
                    end else begin
                        shadow_sigs[shadow_count] = sig;
                        add_beat(shadow_count, 1'b1, 1'b0, 1'b1, sig, 1'b1);
                        shadow_count++;
                    end
                end
            end
            FUNC_READ: begin
                if (int'(eid) < shadow_count)
                    add_beat(int'(eid), 1'b0, 1'b0, 1'b1, shadow_sigs[eid], 1'b1);
                else
                    add_beat(int'(eid), 1'b0, 1'b0, 1'b0, '0, 1'b1);
            end
            FUNC_QUERY: begin
                if (sig != '0) begin
                    for (int i = 0; i < shadow_count; i++) begin
                        if ((shadow_sigs[i] & need) == need &&
                            (shadow_sigs[i] & without_bits) == '0)
                            add_beat(i, 1'b0, 1'b0, 1'b1, shadow_sigs[i], 1'b0);
                    end
                end
                if (op_results.size() == 0)
                    add_beat(0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
                else
                    op_results[op_results.size() - 1].last = 1'b1;
            end
            default: add_beat(0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
        endcase
    endfunction

    function automatic logic [MASK_W-1:0] random_signature();
        logic [MASK_W-1:0] pick;
        case ($urandom_range(0, 3))
            0: pick = $urandom();
            1: pick = $urandom() & $urandom() & $urandom();
            2: pick = (32'hFF << (8 * $urandom_range(0, 3))) & $urandom();
            default: pick = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
        endcase
        return pick;
    endfunction

    // presents one request beat, holds it until taken, then books its results
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [MASK_W-1:0] sig,
                                input logic [MASK_W-1:0] also,
                                input logic [MASK_W-1:0] without,
                                input logic [ID_W-1:0] eid, input logic typed,
                                input t_res want);
        i_valid        <= 1'b1;
        i_func         <= func;
        i_sig_mask     <= sig;
        i_with_mask    <= also;
        i_without_mask <= without;
        i_entry_id     <= eid;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_table_op(func, sig, also, without, eid);
        if (typed)
            table_results_due.push_back(want);
        else
            foreach (op_results[k]) table_results_due.push_back(op_results[k]);
    endtask

    // bursts of back-to-back beats separated by random gaps
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                      : $urandom_range(0, 8);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (table_results_due.size() != 0) @(posedge i_clk);
    endtask

    // receiver: picks a new stall pattern each time its phase counter runs out
    always @(posedge i_clk) begin
        if (ready_phase == 0) begin
            ready_mode  <= $urandom_range(0, 3);
            ready_phase <= $urandom_range(16, 80);
        end else begin
            ready_phase <= ready_phase - 1;
        end
        case (ready_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            2: i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= (ready_phase % 7) < 2;
        endcase
    end

    // result checker: every beat against the oldest expectation
    always @(posedge i_clk) begin : check_beats
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (table_results_due.size() == 0) begin
                report_mismatch($sformatf("beat %0d arrived with nothing expected", beat_count));
            end else begin
                want = table_results_due.pop_front();
                if (o_result_id !== want.result_id)
                    report_mismatch($sformatf("beat %0d result_id %0d, expected %0d",
                                              beat_count, o_result_id, want.result_id));
                if (o_created !== want.created)
                    report_mismatch($sformatf("beat %0d created %b, expected %b",
                                              beat_count, o_created, want.created));
                if (o_full_res !== want.full_res)
                    report_mismatch($sformatf("beat %0d full_res %b, expected %b",
                                              beat_count, o_full_res, want.full_res));
                if (o_valid_res !== want.valid_res)
                    report_mismatch($sformatf("beat %0d valid_res %b, expected %b",
                                              beat_count, o_valid_res, want.valid_res));
                if (o_sig_out !== want.sig_out)
                    report_mismatch($sformatf("beat %0d sig_out %h, expected %h",
                                              beat_count, o_sig_out, want.sig_out));
                if (o_last !== want.last)
                    report_mismatch($sformatf("beat %0d last %b, expected %b",
                                              beat_count, o_last, want.last));
            end
            beat_count++;
        end
    end

    // watchdog: too long without any beat on either channel ends the run
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        t_stim_row         row;
        int                choice;
        logic [FUNC_W-1:0] func;
        logic [MASK_W-1:0] sig;
        logic [MASK_W-1:0] also;
        logic [MASK_W-1:0] without;
        logic [MASK_W-1:0] base;
        logic [ID_W-1:0]   eid;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: extremes, every function, the special cases
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            row = DIRECTED_ROWS[r];
            send_request(row.func, row.sig, row.also, row.without, row.eid, row.typed,
                         row.want);
            pace_sender();
        end
        drain_results();

        // random traffic; fresh signatures come often enough to fill the table,
        // queries are mostly built around stored entries so that they hit
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain_results();
            choice  = $urandom_range(0, 99);
            func    = FUNC_FIND;
            sig     = random_signature();
            also    = $urandom();
            without = $urandom();
            eid     = ID_W'($urandom_range(0, 63));
            if (choice < 40) begin
                // fresh signature: usually a create, later refused on a full table
            end else if (choice < 52) begin
                if (shadow_count > 0)
                    sig = shadow_sigs[$urandom_range(0, shadow_count - 1)];
            end else if (choice < 70) begin
                func = FUNC_READ;
                if (shadow_count > 0 && $urandom_range(0, 1) == 1)
                    eid = ID_W'($urandom_range(0, shadow_count - 1));
            end else if (choice < 95) begin
                func = FUNC_QUERY;
                if (shadow_count > 0 && $urandom_range(0, 4) != 0) begin
                    base    = shadow_sigs[$urandom_range(0, shadow_count - 1)];
                    sig     = base & random_signature();
                    also    = ($urandom_range(0, 1) == 1) ? (base & $urandom()) : '0;
                    without = ($urandom_range(0, 1) == 1) ? (~base & $urandom() & $urandom())
                                                          : '0;
                end
            end else begin
                func = FUNC_SPARE;
            end
            send_request(func, sig, also, without, eid, 1'b0, NO_TYPE);
            pace_sender();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (table_results_due.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived",
                                      table_results_due.size()));
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
